[src/pidf_pkg.sv]
`timescale 1ns / 1ps
package pidf_pkg;

  localparam int unsigned MplierW = 33;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CntW    = 7;

  localparam logic [CntW-1:0] MulSteps = 7'd33;
  localparam logic [CntW-1:0] DivSteps = 7'd64;

  localparam logic [MplierW-1:0] MicrosPerSec = 33'd1000000;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_KP    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KI    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KD    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_KF    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_FLOOR = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_CEIL  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_ILIM  = 3'd6;

  localparam logic signed [64:0] DerivMax = 65'sd2147483647;
  localparam logic signed [64:0] DerivMin = -65'sd2147483648;

  localparam logic signed [31:0] FloorRst = -32'sd65536;
  localparam logic signed [31:0] CeilRst  = 32'sd65536;
  localparam logic [30:0]        IlimRst  = 31'd65536000;

  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  typedef enum logic {
    MU_MUL,
    MU_DIV
  } mu_op_t;

  typedef struct packed {
    logic   go;
    mu_op_t op;
  } mu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mu_stat_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage

[src/pidf_muldiv.sv]
`timescale 1ns / 1ps
// Shared bit-serial unit: shift-add multiply (one multiplier bit a cycle) and
// restoring divide (one quotient bit a cycle). Unsigned magnitudes only.
module pidf_muldiv (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pidf_pkg::mu_req_t       req,
  input  logic [63:0]             op_a,
  input  logic [32:0]             op_b,
  output pidf_pkg::mu_stat_t      stat,
  output logic [63:0]             result
);
  import pidf_pkg::*;

  mu_op_t          op_r;
  logic            busy_r;
  logic            done_r;
  logic [CntW-1:0] cnt_r;
  logic [63:0]     acc_r;    // product, or dividend shifting into quotient
  logic [63:0]     mcand_r;  // multiplicand, or divisor in the low half
  logic [32:0]     mplier_r;
  logic [32:0]     rem_r;

  logic [32:0] trial;
  logic        fits;

  assign trial = {rem_r[31:0], acc_r[63]};
  assign fits  = trial >= {1'b0, mcand_r[31:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= MU_MUL;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r   <= 1'b1;
        op_r     <= req.op;
        rem_r    <= '0;
        mplier_r <= op_b;
        if (req.op == MU_MUL) begin
          acc_r   <= '0;
          mcand_r <= op_a;
          cnt_r   <= MulSteps - 7'd1;
        end else begin
          acc_r   <= op_a;
          mcand_r <= {32'd0, op_b[31:0]};
          cnt_r   <= DivSteps - 7'd1;
        end
      end else if (busy_r) begin
        if (op_r == MU_MUL) begin
          if (mplier_r[0]) acc_r <= acc_r + mcand_r;
          mcand_r  <= {mcand_r[62:0], 1'b0};
          mplier_r <= {1'b0, mplier_r[32:1]};
        end else begin
          rem_r <= fits ? trial - {1'b0, mcand_r[31:0]} : trial;
          acc_r <= {acc_r[62:0], fits};
        end
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign result    = acc_r;

endmodule

[src/pidf_controller_step_unit.sv]
`timescale 1ns / 1ps
// PIDF controller step, Q16.16 fixed point, 32-bit wrapping microsecond time.
// Input channel (in_*): one request per sample; action update or clear.
//   A clear request is absorbed with no result. After reset, an update before
//   any clear answers drive 0 with priming set; later updates answer a drive value.
// Output channel (out_*): one registered result; held while out_stall is high.
// Config port (cfg_*): write-only, one register per cycle; the user must write only while idle (not enforced).
// Timing: all arithmetic runs through one bit-serial multiply/divide unit.
//   Derivative: 33-step multiply + 64-step divide (skipped when dt is 0).
//   Integral:   33-step multiply + 64-step divide.
//   Output:     four 33-step multiplies, one per gain term.
//   Each operation is launched by a registered request and handed off on its
//   done strobe; clear and priming requests do not use the unit.
// in_stall is high while a request is being worked on; a finished result may
// wait in the output register while the next request is taken.
// Reset (synchronous, rst_n low): gains 0, limits -1.0/+1.0, integral limit
// 1000.0, integral, last error and last time cleared, controller unprimed.
module pidf_controller_step_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic signed [31:0] in_error_value,
  input  logic signed [31:0] in_velocity_value,
  input  logic [31:0]        in_time_us,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_drive_value,
  output logic               out_priming,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import pidf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DMUL,
    S_DDIV,
    S_IMUL,
    S_IDIV,
    S_TERM,
    S_CLAMP,
    S_PUT
  } state_t;

  state_t state_r;

  // configuration
  logic signed [31:0] kp_r, ki_r, kd_r, kf_r, floor_r, ceil_r;
  logic [30:0]        ilim_r;

  // controller state
  logic               started_r;
  logic signed [31:0] integ_r;
  logic signed [31:0] last_err_r;
  logic [31:0]        last_time_r;

  // per-request working registers
  logic signed [31:0] err_r, vel_r, deriv_r, drv_r;
  logic [31:0]        dt_r;
  logic               dneg_r, tneg_r, prime_r;
  logic [1:0]         k_r;
  logic signed [49:0] sum_r;

  logic               out_valid_r, out_prime_r;
  logic signed [31:0] out_drive_r;

  mu_req_t     req_r;
  logic [63:0] opa_r;
  logic [32:0] opb_r;
  mu_stat_t    mu_stat;
  logic [63:0] mu_res;

  pidf_muldiv u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req_r),
    .op_a   (opa_r),
    .op_b   (opb_r),
    .stat   (mu_stat),
    .result (mu_res)
  );

  logic               in_acc;
  logic               mu_launch;
  logic signed [32:0] diff;
  logic [32:0]        diff_mag;
  logic [31:0]        dt_now;
  logic signed [64:0] dsv;
  logic signed [31:0] deriv_sat;
  logic signed [46:0] qv, isum, lim;
  logic signed [31:0] integ_new;
  logic signed [63:0] pv;
  logic signed [49:0] sum_nxt, fl50, ce50;
  logic [1:0]         tsel;
  logic signed [31:0] tg, tx;
  logic               out_free;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // a new operation starts on every handoff except after the last gain term, and on a started update
  assign mu_launch = mu_stat.done ? !(state_r == S_TERM && k_r == 2'd3)
                                  : (in_acc && in_action == ACT_UPDATE && started_r);

  assign diff     = {in_error_value[31], in_error_value} - {last_err_r[31], last_err_r};
  assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
  assign dt_now   = in_time_us - last_time_r;

  // derivative: signed quotient saturated to 32 bits
  assign dsv = dneg_r ? -$signed({1'b0, mu_res}) : $signed({1'b0, mu_res});
  always_comb begin
    if (dsv > DerivMax)      deriv_sat = DerivMax[31:0];
    else if (dsv < DerivMin) deriv_sat = DerivMin[31:0];
    else                     deriv_sat = dsv[31:0];
  end

  // integral: quotient is below 2^44, add and clamp to the limit
  assign qv   = err_r[31] ? -$signed({1'b0, mu_res[45:0]}) : $signed({1'b0, mu_res[45:0]});
  assign isum = {{15{integ_r[31]}}, integ_r} + qv;
  assign lim  = $signed({16'd0, ilim_r});
  always_comb begin
    if (isum > lim)       integ_new = lim[31:0];
    else if (isum < -lim) integ_new = 32'(-lim);
    else                  integ_new = isum[31:0];
  end

  // gain term: signed product, floor to Q16.16 by dropping 16 bits
  assign pv      = tneg_r ? -$signed(mu_res) : $signed(mu_res);
  assign sum_nxt = sum_r + {{2{pv[63]}}, pv[63:16]};
  assign fl50    = {{18{floor_r[31]}}, floor_r};
  assign ce50    = {{18{ceil_r[31]}}, ceil_r};

  assign tsel = (state_r == S_TERM) ? k_r + 2'd1 : 2'd0;
  always_comb begin
    case (tsel)
      2'd0:    begin tg = kp_r; tx = err_r;   end
      2'd1:    begin tg = ki_r; tx = integ_r; end
      2'd2:    begin tg = kd_r; tx = deriv_r; end
      default: begin tg = kf_r; tx = vel_r;   end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kp_r        <= '0;
      ki_r        <= '0;
      kd_r        <= '0;
      kf_r        <= '0;
      floor_r     <= FloorRst;
      ceil_r      <= CeilRst;
      ilim_r      <= IlimRst;
      started_r   <= 1'b0;
      integ_r     <= '0;
      last_err_r  <= '0;
      last_time_r <= '0;
      out_valid_r <= 1'b0;
      req_r       <= '{go: 1'b0, op: MU_MUL};
    end else begin
      if (!mu_launch) req_r.go <= 1'b0;
      // S_PUT owns the output valid while it is loading a result
      if (out_valid_r && !out_stall && state_r != S_PUT) out_valid_r <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_KP:    kp_r    <= cfg_data;
          CFG_KI:    ki_r    <= cfg_data;
          CFG_KD:    kd_r    <= cfg_data;
          CFG_KF:    kf_r    <= cfg_data;
          CFG_FLOOR: floor_r <= cfg_data;
          CFG_CEIL:  ceil_r  <= cfg_data;
          CFG_ILIM:  ilim_r  <= cfg_data[30:0];
          default:   ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_action == ACT_CLEAR) begin
              last_err_r  <= '0;
              last_time_r <= '0;
              started_r   <= 1'b1;
            end else if (!started_r) begin
              started_r   <= 1'b1;
              last_time_r <= in_time_us;
              drv_r       <= '0;
              prime_r     <= 1'b1;
              state_r     <= S_PUT;
            end else begin
              err_r       <= in_error_value;
              vel_r       <= in_velocity_value;
              dt_r        <= dt_now;
              dneg_r      <= diff[32];
              last_err_r  <= in_error_value;
              last_time_r <= in_time_us;
              prime_r     <= 1'b0;
              sum_r       <= '0;
              req_r       <= '{go: 1'b1, op: MU_MUL};
              if (dt_now != '0) begin
                // |diff| * 1e6, then divide by dt
                opa_r   <= {31'd0, diff_mag};
                opb_r   <= MicrosPerSec;
                state_r <= S_DMUL;
              end else begin
                deriv_r <= '0;
                opa_r   <= {32'd0, mag32(in_error_value)};
                opb_r   <= {1'b0, dt_now};
                state_r <= S_IMUL;
              end
            end
          end
        end
        S_DMUL: begin
          if (mu_stat.done) begin
            req_r   <= '{go: 1'b1, op: MU_DIV};
            opa_r   <= mu_res;
            opb_r   <= {1'b0, dt_r};
            state_r <= S_DDIV;
          end
        end
        S_DDIV: begin
          if (mu_stat.done) begin
            deriv_r <= deriv_sat;
            req_r   <= '{go: 1'b1, op: MU_MUL};
            opa_r   <= {32'd0, mag32(err_r)};
            opb_r   <= {1'b0, dt_r};
            state_r <= S_IMUL;
          end
        end
        S_IMUL: begin
          if (mu_stat.done) begin
            req_r   <= '{go: 1'b1, op: MU_DIV};
            opa_r   <= mu_res;
            opb_r   <= MicrosPerSec;
            state_r <= S_IDIV;
          end
        end
        S_IDIV: begin
          if (mu_stat.done) begin
            integ_r <= integ_new;
            k_r     <= 2'd0;
            req_r   <= '{go: 1'b1, op: MU_MUL};
            opa_r   <= {32'd0, mag32(tg)};
            opb_r   <= {1'b0, mag32(tx)};
            tneg_r  <= tg[31] ^ tx[31];
            state_r <= S_TERM;
          end
        end
        S_TERM: begin
          if (mu_stat.done) begin
            sum_r <= sum_nxt;
            if (k_r == 2'd3) begin
              state_r <= S_CLAMP;
            end else begin
              k_r    <= k_r + 2'd1;
              req_r  <= '{go: 1'b1, op: MU_MUL};
              opa_r  <= {32'd0, mag32(tg)};
              opb_r  <= {1'b0, mag32(tx)};
              tneg_r <= tg[31] ^ tx[31];
            end
          end
        end
        S_CLAMP: begin
          // floor takes precedence when the limits are crossed
          if (sum_r < fl50)      drv_r <= floor_r;
          else if (sum_r > ce50) drv_r <= ceil_r;
          else                   drv_r <= sum_r[31:0];
          state_r <= S_PUT;
        end
        S_PUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_drive_r <= drv_r;
            out_prime_r <= prime_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_value = out_drive_r;
  assign out_priming     = out_prime_r;

  a_prime_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_priming) |-> (out_drive_value == '0))
    else $error("priming result carries a nonzero drive");

  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req_r.go |-> !mu_stat.busy)
    else $error("muldiv launched while busy");

  a_done_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    mu_stat.done |-> (state_r != S_IDLE && state_r != S_PUT && state_r != S_CLAMP))
    else $error("muldiv finished outside a compute state");

  a_update_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_action == ACT_UPDATE && started_r) |=> (state_r != S_IDLE))
    else $error("started update request left the controller idle");

endmodule
